// ----- design/sbra_pkg.sv -----
// shared types, constants and helpers for the sector bitmap allocator
`default_nettype none

package sbra_pkg;

   localparam int SECTORS   = 65536;
   localparam int MAX_BATCH = 64;
   localparam int WORD_W    = 32;
   localparam int MAP_WORDS = SECTORS / WORD_W;
   localparam int ADDR_W    = $clog2(MAP_WORDS);
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int SEC_W     = 16;
   localparam int CNT_W     = 7;
   localparam int LIM_W     = 17;

   typedef enum logic [1:0] {
      FN_CLAIM   = 2'd0,
      FN_RELEASE = 2'd1,
      FN_CHECK   = 2'd2,
      FN_NOP     = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SCAN,
      ST_WRITE,
      ST_FINISH
   } state_type;

   // index of the lowest set bit, zero when none is set
   function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ----- design/sector_bitmap_reclaim_allocator_core.sv -----
// sector bitmap allocator: mark store, word sequencer and result register
//
// Keeps one mark bit per sector in a 2048 x 32 bit memory. Items come in on the
// req_ channel: func 0 claims free sectors (first fit from sector 0, below the
// sector count held in the csr_ register), func 1 releases one sector, func 2
// checks one sector, func 3 does nothing. Every item gives one or more result
// items on the rsp_ channel, the final one with rsp_tlast high.
// After reset a clearing pass writes one memory word a cycle while
// req_tready stays low; csr_ writes are taken at any time.
// A release passes the read, load, write and finish states before its result;
// a check skips the write. A claim walks the memory one word at a time
// through a single read/modify/write path (read, load, scan, write), granting
// sectors in the scan, then gives the final result. req_tready is high only
// while no item is in work.
// Results leave from an output register; a claim holds its latest grant back
// one step so that the last grant can carry tlast. When the receiver stalls
// the sequencer waits with its grant and resumes once the register drains.
`default_nettype none

module sector_bitmap_reclaim_allocator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // func[1:0], sector[17:2], count[24:18]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // granted_sector[15:0], blocked[16]
   output logic             rsp_tuser,   // granted
   output logic             rsp_tlast,   // is_last
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [16:0] csr_data     // sector_count
);

   localparam int AW = sbra_pkg::ADDR_W;
   localparam int BW = sbra_pkg::BIT_W;
   localparam int WW = sbra_pkg::WORD_W;
   localparam int SW = sbra_pkg::SEC_W;
   localparam int CW = sbra_pkg::CNT_W;
   localparam int LW = sbra_pkg::LIM_W;

   logic [WW-1:0] mark_mem [sbra_pkg::MAP_WORDS];
   logic [WW-1:0] rdata_ff;

   sbra_pkg::state_type state_ff, state_in;
   sbra_pkg::func_type  func_ff, func_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [WW-1:0] word_ff, word_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] want_ff, want_in;
   logic          blocked_ff, blocked_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [SW-1:0] pend_sector_ff, pend_sector_in;
   logic [LW-1:0] sector_count_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_sector_ff, rsp_sector_in;
   logic          rsp_granted_ff, rsp_granted_in;
   logic          rsp_blocked_ff, rsp_blocked_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          mem_we;
   logic [WW-1:0] mem_wdata;

   logic [LW-1:0] limit;
   logic [LW-1:0] word_base;
   logic [LW-1:0] next_base;
   logic [LW-1:0] rem;
   logic [WW-1:0] valid_mask;
   logic [WW-1:0] free_mask;
   logic [BW-1:0] free_idx;
   logic          slot_free;
   logic          req_fire;
   logic [1:0]    req_func;
   logic [SW-1:0] req_sector;
   logic [CW-1:0] req_count;
   logic [CW-1:0] want_sat;

   assign req_func   = req_tdata[1:0];
   assign req_sector = req_tdata[17:2];
   assign req_count  = req_tdata[24:18];

   assign limit = (sector_count_ff > LW'(sbra_pkg::SECTORS)) ?
                  LW'(sbra_pkg::SECTORS) : sector_count_ff;
   assign word_base = LW'({addr_ff, {BW{1'b0}}});
   assign next_base = word_base + LW'(WW);
   assign rem       = limit - word_base;
   // partial last word: only bits below the limit may be handed out
   assign valid_mask = (rem >= LW'(WW)) ? {WW{1'b1}} :
                       ((WW'(1) << rem[BW-1:0]) - WW'(1));
   assign free_mask  = ~word_ff & valid_mask;
   assign free_idx   = sbra_pkg::lowest_one(free_mask);
   assign want_sat   = (req_count > CW'(sbra_pkg::MAX_BATCH)) ?
                       CW'(sbra_pkg::MAX_BATCH) : req_count;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == sbra_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_blocked_ff, rsp_sector_ff};
   assign rsp_tuser  = rsp_granted_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      addr_in        = addr_ff;
      bit_in         = bit_ff;
      word_in        = word_ff;
      cnt_in         = cnt_ff;
      want_in        = want_ff;
      blocked_in     = blocked_ff;
      pend_valid_in  = pend_valid_ff;
      pend_sector_in = pend_sector_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_sector_in  = rsp_sector_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      mem_wdata      = word_ff;

      case (state_ff)
         sbra_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            addr_in   = addr_ff + AW'(1);
            if (addr_ff == AW'(sbra_pkg::MAP_WORDS - 1)) begin
               state_in = sbra_pkg::ST_IDLE;
            end
         end
         sbra_pkg::ST_IDLE: begin
            if (req_fire) begin
               func_in       = sbra_pkg::func_type'(req_func);
               addr_in       = req_sector[SW-1:BW];
               bit_in        = req_sector[BW-1:0];
               cnt_in        = '0;
               want_in       = want_sat;
               blocked_in    = 1'b0;
               pend_valid_in = 1'b0;
               case (sbra_pkg::func_type'(req_func))
                  sbra_pkg::FN_CLAIM: begin
                     addr_in = '0;
                     if (want_sat != '0 && limit != '0) begin
                        state_in = sbra_pkg::ST_READ;
                     end else begin
                        state_in = sbra_pkg::ST_FINISH;
                     end
                  end
                  sbra_pkg::FN_RELEASE, sbra_pkg::FN_CHECK: begin
                     state_in = sbra_pkg::ST_READ;
                  end
                  default: begin
                     state_in = sbra_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         sbra_pkg::ST_READ: begin
            state_in = sbra_pkg::ST_LOAD;
         end
         sbra_pkg::ST_LOAD: begin
            case (func_ff)
               sbra_pkg::FN_CLAIM: begin
                  word_in  = rdata_ff;
                  state_in = sbra_pkg::ST_SCAN;
               end
               sbra_pkg::FN_RELEASE: begin
                  word_in  = rdata_ff & ~(WW'(1) << bit_ff);
                  state_in = sbra_pkg::ST_WRITE;
               end
               default: begin
                  blocked_in = rdata_ff[bit_ff];
                  state_in   = sbra_pkg::ST_FINISH;
               end
            endcase
         end
         sbra_pkg::ST_SCAN: begin
            if (free_mask != '0 && cnt_ff < want_ff) begin
               // the held grant goes out once a later one is known to exist
               if (!pend_valid_ff || slot_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_sector_in  = pend_sector_ff;
                     rsp_granted_in = 1'b1;
                     rsp_blocked_in = 1'b0;
                     rsp_last_in    = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_sector_in = {addr_ff, free_idx};
                  word_in        = word_ff | (WW'(1) << free_idx);
                  cnt_in         = cnt_ff + CW'(1);
               end
            end else begin
               state_in = sbra_pkg::ST_WRITE;
            end
         end
         sbra_pkg::ST_WRITE: begin
            mem_we = 1'b1;
            if (func_ff == sbra_pkg::FN_CLAIM && cnt_ff < want_ff && next_base < limit) begin
               addr_in  = addr_ff + AW'(1);
               state_in = sbra_pkg::ST_READ;
            end else begin
               state_in = sbra_pkg::ST_FINISH;
            end
         end
         sbra_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_sector_in  = pend_valid_ff ? pend_sector_ff : '0;
               rsp_granted_in = pend_valid_ff;
               rsp_blocked_in = (func_ff == sbra_pkg::FN_CHECK) && blocked_ff;
               rsp_last_in    = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = sbra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbra_pkg::ST_IDLE;
         end
      endcase
   end

   // mark store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mark_mem[addr_ff] <= mem_wdata;
      end
      rdata_ff <= mark_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= sbra_pkg::ST_CLEAR;
         addr_ff         <= '0;
         cnt_ff          <= '0;
         want_ff         <= '0;
         func_ff         <= sbra_pkg::FN_NOP;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         sector_count_ff <= LW'(sbra_pkg::SECTORS);
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         cnt_ff        <= cnt_in;
         want_ff       <= want_in;
         func_ff       <= func_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            sector_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      bit_ff         <= bit_in;
      word_ff        <= word_in;
      blocked_ff     <= blocked_in;
      pend_sector_ff <= pend_sector_in;
      rsp_sector_ff  <= rsp_sector_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_last_ff    <= rsp_last_in;
   end

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == sbra_pkg::ST_CLEAR |-> !rsp_valid_ff)
      else $error("result presented during clearing pass");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= want_ff)
      else $error("more grants than requested");

   a_pend_claim: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> func_ff == sbra_pkg::FN_CLAIM)
      else $error("held grant outside a claim");

   a_mid_is_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_granted_ff)
      else $error("non-final result that is not a grant");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == sbra_pkg::ST_IDLE |-> !pend_valid_ff)
      else $error("grant left behind after an item");

endmodule

`default_nettype wire
